// ===== design/sfta_pkg.sv =====
// Shared types, constants and index helpers for the strip and fan triangle assembler.
`default_nettype none

package sfta_pkg;

   localparam int MaxStrip   = 64;
   localparam int IndexBits  = 16;
   localparam int CountBits  = $clog2(MaxStrip + 1);
   localparam int BaseBits   = IndexBits + 1;
   localparam int SumBits    = BaseBits + 1;
   localparam int FieldBits  = 16;
   localparam int LimitBits  = 16;

   localparam logic [BaseBits-1:0] BaseMax = {BaseBits{1'b1}};
   localparam logic [CountBits-1:0] StripMax = CountBits'(MaxStrip);

   typedef enum logic {
      OP_HEADER = 1'b0,
      OP_VERTEX = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic signed [7:0] strip_count;
      logic [15:0]      vertex_ref;
   } item_type;

   typedef struct packed {
      logic [15:0] out_vertex_ref;
      logic        has_triangle;
      logic [15:0] idx_a;
      logic [15:0] idx_b;
      logic [15:0] idx_c;
      logic        overflow;
   } result_type;

   // Low index bits of a sum, widened or cut to the output field width.
   function automatic logic [FieldBits-1:0] index_bits(input logic [SumBits-1:0] v);
      logic [IndexBits-1:0] low;
      low = v[IndexBits-1:0];
      return FieldBits'(low);
   endfunction

   function automatic logic index_over(input logic [SumBits-1:0] v);
      return v[SumBits-1:IndexBits] != '0;
   endfunction

   // Base advance with saturation at the top of the base range.
   function automatic logic [BaseBits-1:0] base_add(input logic [BaseBits-1:0] b,
                                                    input logic [CountBits-1:0] n);
      logic [SumBits-1:0] s;
      s = SumBits'(b) + SumBits'(n);
      return (s > SumBits'(BaseMax)) ? BaseMax : s[BaseBits-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/sfta_core.sv =====
// Command state and triangle index generation for one registered word.
`default_nettype none

module sfta_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          item_valid,
   input  sfta_pkg::item_type           item,
   input  wire [sfta_pkg::LimitBits-1:0] command_limit,
   input  wire                          out_free,
   output logic                         take,
   output logic                         result_load,
   output sfta_pkg::result_type         result
);

   logic [sfta_pkg::BaseBits-1:0]  base_offset_ff, base_offset_in;
   logic                           list_ended_ff, list_ended_in;
   logic                           fan_mode_ff, fan_mode_in;
   logic [sfta_pkg::CountBits-1:0] command_size_ff, command_size_in;
   logic [sfta_pkg::CountBits-1:0] vertex_position_ff, vertex_position_in;
   logic [sfta_pkg::LimitBits-1:0] commands_seen_ff, commands_seen_in;

   logic                           produces;
   logic                           header_ok;
   logic [7:0]                     magnitude;
   logic [sfta_pkg::CountBits-1:0] clamped;
   logic [sfta_pkg::CountBits-1:0] next_position;
   logic [sfta_pkg::SumBits-1:0]   sum_hi, sum_mid, sum_lo;
   logic [sfta_pkg::SumBits-1:0]   tri_a, tri_b, tri_c;

   always_comb begin
      produces  = (item.op == sfta_pkg::OP_VERTEX) && !list_ended_ff &&
                  (vertex_position_ff < command_size_ff);
      header_ok = (item.op == sfta_pkg::OP_HEADER) && !list_ended_ff &&
                  (commands_seen_ff < command_limit);
      take        = item_valid && (!produces || out_free);
      result_load = take && produces;

      magnitude = item.strip_count[7] ? (8'd0 - item.strip_count) : item.strip_count;
      clamped   = (magnitude > 8'(sfta_pkg::MaxStrip)) ? sfta_pkg::StripMax
                                                         : magnitude[sfta_pkg::CountBits-1:0];
      next_position = vertex_position_ff + 1'b1;

      sum_hi  = sfta_pkg::SumBits'(base_offset_ff) + sfta_pkg::SumBits'(vertex_position_ff);
      sum_mid = sum_hi - 1'b1;
      sum_lo  = sum_hi - 2'd2;
      if (fan_mode_ff) begin
         tri_a = sum_hi;
         tri_b = sum_mid;
         tri_c = sfta_pkg::SumBits'(base_offset_ff);
      end else if (!vertex_position_ff[0]) begin
         tri_a = sum_hi;
         tri_b = sum_mid;
         tri_c = sum_lo;
      end else begin
         tri_a = sum_lo;
         tri_b = sum_mid;
         tri_c = sum_hi;
      end

      result.out_vertex_ref = item.vertex_ref;
      result.has_triangle   = 1'b0;
      result.idx_a          = '0;
      result.idx_b          = '0;
      result.idx_c          = '0;
      result.overflow       = 1'b0;
      if (vertex_position_ff >= sfta_pkg::CountBits'(2)) begin
         result.has_triangle = 1'b1;
         result.idx_a        = sfta_pkg::index_bits(tri_a);
         result.idx_b        = sfta_pkg::index_bits(tri_b);
         result.idx_c        = sfta_pkg::index_bits(tri_c);
         result.overflow     = sfta_pkg::index_over(tri_a) || sfta_pkg::index_over(tri_b) ||
                               sfta_pkg::index_over(tri_c);
      end

      base_offset_in     = base_offset_ff;
      list_ended_in      = list_ended_ff;
      fan_mode_in        = fan_mode_ff;
      command_size_in    = command_size_ff;
      vertex_position_in = vertex_position_ff;
      commands_seen_in   = commands_seen_ff;
      if (take && header_ok) begin
         base_offset_in     = sfta_pkg::base_add(base_offset_ff, vertex_position_ff);
         vertex_position_in = '0;
         command_size_in    = '0;
         if (item.strip_count == 8'sd0) begin
            list_ended_in = 1'b1;
         end else begin
            fan_mode_in      = item.strip_count[7];
            command_size_in  = clamped;
            commands_seen_in = commands_seen_ff + 1'b1;
         end
      end else if (result_load) begin
         vertex_position_in = next_position;
         if (next_position >= command_size_ff) begin
            base_offset_in     = sfta_pkg::base_add(base_offset_ff, command_size_ff);
            vertex_position_in = '0;
            command_size_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_offset_ff     <= '0;
         list_ended_ff      <= 1'b0;
         fan_mode_ff        <= 1'b0;
         command_size_ff    <= '0;
         vertex_position_ff <= '0;
         commands_seen_ff   <= '0;
      end else begin
         base_offset_ff     <= base_offset_in;
         list_ended_ff      <= list_ended_in;
         fan_mode_ff        <= fan_mode_in;
         command_size_ff    <= command_size_in;
         vertex_position_ff <= vertex_position_in;
         commands_seen_ff   <= commands_seen_in;
      end
   end

   a_idle_position : assert property (@(posedge clock) disable iff (reset)
      command_size_ff == '0 |-> vertex_position_ff == '0)
      else $error("vertex position set with no open command");

   a_size_clamped : assert property (@(posedge clock) disable iff (reset)
      command_size_ff <= sfta_pkg::StripMax)
      else $error("command size beyond the strip limit");

   a_ended_frozen : assert property (@(posedge clock) disable iff (reset)
      list_ended_ff |=> list_ended_ff && $stable(base_offset_ff) &&
                        $stable(commands_seen_ff))
      else $error("state changed after the list end");

   a_result_is_vertex : assert property (@(posedge clock) disable iff (reset)
      result_load |-> item_valid && item.op == sfta_pkg::OP_VERTEX)
      else $error("result loaded from a header word");

endmodule

`default_nettype wire

// ===== design/sfta_out_stage.sv =====
// Result register that holds one word until the downstream side takes it.
`default_nettype none

module sfta_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  sfta_pkg::result_type load_data,
   input  wire                  out_ready,
   output logic                 out_valid,
   output sfta_pkg::result_type out_data,
   output logic                 free
);

   logic                 valid_ff, valid_in;
   sfta_pkg::result_type data_ff, data_in;

   always_comb begin
      free     = !valid_ff || out_ready;
      valid_in = load || (valid_ff && !out_ready);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== design/strip_fan_triangle_assembler_unit.sv =====
// Top level of the strip and fan primitive assembler.
// Each word is held in the input register, where the command logic evaluates it, and
// once the word is taken its result is loaded into the result register, which presents
// the result word until the downstream side takes it. One word is accepted per
// cycle as long as the result register drains. Header words and ignored words produce
// no result. The command limit may be written only while no word is in flight.
`default_nettype none

module strip_fan_triangle_assembler_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // strip_count [7:0], vertex_ref [23:8]
   input  wire         req_tuser,  // op [0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,  // out_vertex_ref, idx_a, idx_b, idx_c, overflow, zero fill
   output logic        rsp_tuser   // has_triangle [0]
);

   logic [sfta_pkg::LimitBits-1:0] command_limit_ff;
   logic                           stage_valid_ff, stage_valid_in;
   sfta_pkg::item_type             stage_item_ff, stage_item_in;
   logic                           take;
   logic                           result_load;
   logic                           out_free;
   sfta_pkg::result_type           result;
   sfta_pkg::result_type           rsp_data;

   always_comb begin
      req_tready               = !stage_valid_ff || take;
      stage_valid_in           = (req_tvalid && req_tready) || (stage_valid_ff && !take);
      stage_item_in            = stage_item_ff;
      if (req_tvalid && req_tready) begin
         stage_item_in.op          = sfta_pkg::op_type'(req_tuser);
         stage_item_in.strip_count = req_tdata[7:0];
         stage_item_in.vertex_ref  = req_tdata[23:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff   <= 1'b0;
         command_limit_ff <= 16'hFFFF;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_wr_en) begin
            command_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

   sfta_core u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (stage_valid_ff),
      .item          (stage_item_ff),
      .command_limit (command_limit_ff),
      .out_free      (out_free),
      .take          (take),
      .result_load   (result_load),
      .result        (result)
   );

   sfta_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (result_load),
      .load_data (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_tdata = {7'd0, rsp_data.overflow, rsp_data.idx_c, rsp_data.idx_b,
                       rsp_data.idx_a, rsp_data.out_vertex_ref};
   assign rsp_tuser = rsp_data.has_triangle;

endmodule

`default_nettype wire
